// ===== hdl/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions.
package sha_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Rounds = 64;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic       absorb;     // write input byte into the word buffer
        logic       pad_byte;   // write a padding byte at the fill position
        logic       len_word;   // write length words into words 14 and 15
        logic       init_work;  // copy chain into working registers
        logic       round;      // one compression round
        logic       add_chain;  // fold working registers into chain
        logic       reset_msg;  // restore initial chain, clear counts
        logic       emit_shift; // rotate chain for output
        logic [7:0] pad_value;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [5:0] fill;
        logic       block_full;
    } t_stat;

    function automatic t_word ror(input t_word x, input int unsigned n);
        ror = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word round_k(input logic [5:0] i);
        t_word k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        round_k = k[i];
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h [0:7];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        init_h = h[i];
    endfunction

    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

endpackage

// ===== hdl/sha_if.sv =====
// Valid/ready channel interfaces for input beats and digest beats.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    modport source (output valid, action, data_byte, input ready);
    modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;
    modport source (output valid, digest_word, digest_last, input ready);
    modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ===== hdl/sha_datapath.sv =====
// Datapath: block buffer, message schedule, round logic and chain words.
module sha_datapath
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic [5:0]  i_round,
    output t_stat       o_stat,
    output t_word       o_chain0
);

    t_word      r_w [0:15];
    t_word      r_h [0:7];
    t_word      r_v [0:7];
    logic [5:0] r_fill;
    logic [63:0] r_bits;

    logic [7:0] wr_byte;
    logic       wr_en;
    t_word      w_new, t1, t2, w_cur;

    assign wr_en   = i_cmd.absorb | i_cmd.pad_byte;
    assign wr_byte = i_cmd.absorb ? i_byte : i_cmd.pad_value;
    assign w_cur   = r_w[0];

    // Schedule extension: next word from the 16-word window
    always_comb begin
        w_new = r_w[0] + (ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3))
              + r_w[9] + (ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10));
    end

    // Round function
    always_comb begin
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(i_round) + w_cur;
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Block buffer and schedule window
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (r_fill[1:0])
                2'd0:    r_w[r_fill[5:2]][31:24] <= wr_byte;
                2'd1:    r_w[r_fill[5:2]][23:16] <= wr_byte;
                2'd2:    r_w[r_fill[5:2]][15:8]  <= wr_byte;
                default: r_w[r_fill[5:2]][7:0]   <= wr_byte;
            endcase
        end else if (i_cmd.len_word) begin
            r_w[14] <= r_bits[63:32];
            r_w[15] <= r_bits[31:0];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_work) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // Chain words, fill count and bit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_msg) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.add_chain) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end else if (i_cmd.emit_shift) begin
                for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                r_h[7] <= r_h[0];
            end
            if (wr_en) r_fill <= r_fill + 6'd1;
            if (i_cmd.absorb) r_bits <= r_bits + 64'd8;
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.block_full = i_cmd.absorb && (r_fill == 6'd63);
    assign o_chain0          = r_h[0];

endmodule

// ===== hdl/sha_ctrl.sv =====
// Controller: sequences absorb, padding, compression and digest output.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_action,
    output logic        o_in_ready,
    output logic        o_out_valid,
    output logic        o_out_last,
    input  logic        i_out_ready,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic [5:0]  o_round
);

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_fin, n_fin;     // finishing: padding in progress
    logic       r_mark, n_mark;   // 0x80 already written
    logic       r_last, n_last;   // this compression is the final one

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_mark  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
            r_mark  <= n_mark;
            r_last  <= n_last;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fin   = r_fin;
        n_mark  = r_mark;
        n_last  = r_last;
        o_cmd   = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_action) begin
                        o_cmd.absorb = 1'b1;
                        if (i_stat.block_full) begin
                            n_state = ST_LOAD;
                            n_last  = 1'b0;
                        end
                    end else begin
                        n_fin   = 1'b1;
                        n_mark  = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (r_fin) begin
                    // one padding byte per cycle until the block is ready
                    if (!r_mark) begin
                        o_cmd.pad_byte  = 1'b1;
                        o_cmd.pad_value = PadMark;
                        n_mark = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            n_last = 1'b0;
                            n_state = ST_ROUND;
                            o_cmd.init_work = 1'b1;
                            n_cnt = '0;
                        end
                    end else if (i_stat.fill == LenPos) begin
                        o_cmd.len_word  = 1'b1;
                        o_cmd.init_work = 1'b1;
                        n_last  = 1'b1;
                        n_cnt   = '0;
                        n_state = ST_ROUND;
                    end else begin
                        o_cmd.pad_byte = 1'b1;
                        if (i_stat.fill == 6'd63) begin
                            n_last  = 1'b0;
                            o_cmd.init_work = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_ROUND;
                        end
                    end
                end else begin
                    o_cmd.init_work = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(Rounds - 1)) n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add_chain = 1'b1;
                n_cnt = '0;
                if (r_last)       n_state = ST_EMIT;
                else if (r_fin)   n_state = ST_LOAD;
                else              n_state = ST_IDLE;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                o_out_last  = (r_cnt == 6'd7);
                if (i_out_ready) begin
                    o_cmd.emit_shift = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd7) begin
                        o_cmd.emit_shift = 1'b0;
                        o_cmd.reset_msg  = 1'b1;
                        n_fin   = 1'b0;
                        n_last  = 1'b0;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_round = r_cnt;

endmodule

// ===== hdl/sha256_hasher_core.sv =====
// Absorb beats are taken while idle; the 64th byte of a block starts load, 64 rounds and add.
// Finish: one padding byte per cycle, then 64 rounds and one add per compressed block; the
// load shares the cycle of the last padding byte (byte 63) or of the length write (byte 56);
// two blocks when 56 or more bytes are held; then eight digest beats.
// No byte is taken while a block is compressed, so the single round unit sets the absorb rate.
// Synchronous active-low reset restores the initial chain and clears the counts;
// the block buffer is not cleared.
module sha256_hasher_core
    import sha_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha_in_if.sink        i_in,
    sha_out_if.source     o_out
);

    t_cmd       cmd;
    t_stat      stat;
    logic [5:0] round_idx;
    t_word      chain0;

    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_out_last  (o_out.digest_last),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_round     (round_idx)
    );

    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (i_in.data_byte),
        .i_round  (round_idx),
        .o_stat   (stat),
        .o_chain0 (chain0)
    );

    assign o_out.digest_word = chain0;

endmodule
